FILE: hdl/aids_pkg.sv
// Shared constants and types for the array insert/delete/search unit.
// No dependencies; used by aids_cell, array_insert_delete_search_unit and the testbench.
package aids_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int WORD_W          = 32;
    localparam int FUNC_W          = 2;
    localparam int POS_W           = 5;
    localparam int STATUS_W        = 2;

    localparam logic [FUNC_W-1:0] FN_APPEND = 2'd0;
    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FN_DELETE = 2'd2;
    localparam logic [FUNC_W-1:0] FN_SEARCH = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    // cell update modes
    localparam logic [1:0] MODE_HOLD  = 2'd0;
    localparam logic [1:0] MODE_PUT   = 2'd1;
    localparam logic [1:0] MODE_OPEN  = 2'd2;
    localparam logic [1:0] MODE_CLOSE = 2'd3;

    typedef struct packed {
        logic [1:0]               mode;
        logic signed [WORD_W-1:0] value;
    } cell_ctrl_t;

endpackage

FILE: hdl/array_insert_delete_search_unit.sv
// Top level of the array insert/delete/search unit: command register, control
// and a row of aids_cell slots. Depends on aids_pkg and aids_cell.
//
// A packed table of signed 32-bit words with an entry count. Commands are
// append, insert at a 1-based position, delete first match, and search first
// match; each returns one result word with status, position and count. A
// command is accepted in the idle state and runs in the execute state: the
// accept edge loads it and lets each cell compare its entry to the value, the
// execute edge resolves the first match along the cell chain and updates the
// cells at once. One command is in flight at a time, so a new word is taken
// only once the last has executed; a result waiting in the output register
// stalls the execute state. Table contents need no clearing after reset.
module array_insert_delete_search_unit
    import aids_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [FUNC_W-1:0]          func,
    input  logic signed [WORD_W-1:0]   value,
    input  logic [POS_W-1:0]           position,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [STATUS_W-1:0]        status,
    output logic [POS_W-1:0]           found_position,
    output logic [POS_W-1:0]           entry_count
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg, state_next;
    logic accept, exec_go, out_take;

    logic [FUNC_W-1:0]        func_reg;
    logic signed [WORD_W-1:0] value_reg;
    logic [POS_W-1:0]         pos_reg;

    logic [CW-1:0] count_reg, count_next;

    logic                    out_valid_reg;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [POS_W-1:0]        found_reg;
    logic [POS_W-1:0]        count_out_reg;

    logic signed [WORD_W-1:0] entry_w [TABLE_DEPTH];
    logic [TABLE_DEPTH:0]     before_w;
    logic [TABLE_DEPTH-1:0]   first_w;

    cell_ctrl_t    ctrl;
    logic [PW-1:0] target;
    logic [PW-1:0] where;
    logic [PW-1:0] hit_pos;
    logic [PW-1:0] cnt_w, pos_w;
    logic          full, badpos, any_hit;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid & ~in_stall;
    assign out_take = out_valid_reg & ~out_stall;
    assign exec_go  = (state_reg == ST_EXEC) && (!out_valid_reg || !out_stall);

    assign cnt_w   = PW'(count_reg);
    assign pos_w   = PW'(pos_reg);
    assign full    = (count_reg == FULL_CNT);
    assign badpos  = (pos_reg == '0) || (pos_w > cnt_w + PW'(1));
    assign any_hit = before_w[TABLE_DEPTH];

    assign before_w[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            logic signed [WORD_W-1:0] left_e, right_e;
            if (gi == 0)
            begin : g_first
                assign left_e = entry_w[gi];
            end
            else
            begin : g_mid_l
                assign left_e = entry_w[gi-1];
            end
            if (gi == TABLE_DEPTH - 1)
            begin : g_last
                assign right_e = entry_w[gi];
            end
            else
            begin : g_mid_r
                assign right_e = entry_w[gi+1];
            end

            aids_cell #(
                .IDX (gi),
                .TW  (PW)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmp_en      (accept),
                .cmp_value   (value),
                .count       (cnt_w),
                .exec_en     (exec_go),
                .ctrl        (ctrl),
                .target      (target),
                .left_entry  (left_e),
                .right_entry (right_e),
                .before_in   (before_w[gi]),
                .entry       (entry_w[gi]),
                .before_out  (before_w[gi+1]),
                .first_hit   (first_w[gi])
            );
        end
    endgenerate

    always_comb
    begin
        hit_pos = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (first_w[i])
                hit_pos = hit_pos | PW'(i + 1);
        end
    end

    always_comb
    begin
        status_next = ST_OK;
        where       = '0;
        count_next  = count_reg;
        ctrl.mode   = MODE_HOLD;
        ctrl.value  = value_reg;
        target      = cnt_w;
        unique case (func_reg)
            FN_APPEND:
            begin
                if (full)
                    status_next = ST_FULL;
                else
                begin
                    ctrl.mode  = MODE_PUT;
                    target     = cnt_w;
                    count_next = count_reg + CW'(1);
                    where      = cnt_w + PW'(1);
                end
            end
            FN_INSERT:
            begin
                if (full)
                    status_next = ST_FULL;
                else if (badpos)
                    status_next = ST_BADPOS;
                else
                begin
                    ctrl.mode  = MODE_OPEN;
                    target     = pos_w - PW'(1);
                    count_next = count_reg + CW'(1);
                    where      = pos_w;
                end
            end
            FN_DELETE:
            begin
                if (!any_hit)
                    status_next = ST_NOTFOUND;
                else
                begin
                    ctrl.mode  = MODE_CLOSE;
                    count_next = count_reg - CW'(1);
                    where      = hit_pos;
                end
            end
            FN_SEARCH:
            begin
                if (!any_hit)
                    status_next = ST_NOTFOUND;
                else
                    where = hit_pos;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (exec_go)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_go)
                count_reg <= count_next;
            if (exec_go)
                out_valid_reg <= 1'b1;
            else if (out_take)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= func;
            value_reg <= value;
            pos_reg   <= position;
        end
        if (exec_go)
        begin
            status_reg    <= status_next;
            found_reg     <= where[POS_W-1:0];
            count_out_reg <= POS_W'(count_next);
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign found_position = found_reg;
    assign entry_count    = count_out_reg;

endmodule

FILE: hdl/aids_cell.sv
// One table slot: holds an entry, compares it, and shifts with its neighbors.
// Depends on aids_pkg.
module aids_cell
    import aids_pkg::*;
#(
    parameter int IDX = 0,
    parameter int TW  = 6
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmp_en,
    input  logic signed [WORD_W-1:0] cmp_value,
    input  logic [TW-1:0]            count,
    input  logic                     exec_en,
    input  cell_ctrl_t               ctrl,
    input  logic [TW-1:0]            target,
    input  logic signed [WORD_W-1:0] left_entry,
    input  logic signed [WORD_W-1:0] right_entry,
    input  logic                     before_in,
    output logic signed [WORD_W-1:0] entry,
    output logic                     before_out,
    output logic                     first_hit
);

    localparam logic [TW-1:0] MY_IDX = TW'(IDX);

    logic signed [WORD_W-1:0] entry_reg, entry_next;
    logic                     match_reg, match_next;

    assign match_next = (entry_reg == cmp_value) && (MY_IDX < count);
    assign before_out = before_in | match_reg;
    assign first_hit  = match_reg & ~before_in;
    assign entry      = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        unique case (ctrl.mode)
            MODE_PUT:
            begin
                if (MY_IDX == target)
                    entry_next = ctrl.value;
            end
            MODE_OPEN:
            begin
                if (MY_IDX == target)
                    entry_next = ctrl.value;
                else if (MY_IDX > target)
                    entry_next = left_entry;
            end
            MODE_CLOSE:
            begin
                if (before_out)
                    entry_next = right_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            match_reg <= 1'b0;
        else if (cmp_en)
            match_reg <= match_next;
    end

    always_ff @(posedge clk)
    begin
        if (exec_en)
            entry_reg <= entry_next;
    end

endmodule

FILE: tb/sv/aids_table_checker.sv
// Checker for array_insert_delete_search_unit: watches both word channels,
// predicts each result from a shadow table and compares. Depends on aids_pkg.
module aids_table_checker
    import aids_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic [FUNC_W-1:0]        func,
    input  logic signed [WORD_W-1:0] value,
    input  logic [POS_W-1:0]         position,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic [STATUS_W-1:0]      status,
    input  logic [POS_W-1:0]         found_position,
    input  logic [POS_W-1:0]         entry_count,
    output int                       fail_count,
    output int                       pending,
    output int                       results_checked,
    output int                       table_fill
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    found_position;
        logic [POS_W-1:0]    entry_count;
    } table_result_t;

    logic signed [WORD_W-1:0] shadow_table [TABLE_DEPTH];
    int                       shadow_count;
    table_result_t            awaited_results [$];
    table_result_t            want;

    function automatic int first_hit(input logic signed [WORD_W-1:0] v);
        for (int k = 0; k < shadow_count; k++)
        begin
            if (shadow_table[k] == v)
            begin
                return k + 1;
            end
        end
        return 0;
    endfunction

    function automatic table_result_t apply_command(
        input logic [FUNC_W-1:0]        f,
        input logic signed [WORD_W-1:0] v,
        input logic [POS_W-1:0]         p
    );
        table_result_t r;
        int            hit;
        int            slot;
        r.status         = ST_OK;
        r.found_position = '0;
        slot             = int'(p);
        case (f)
            FN_APPEND:
            begin
                if (shadow_count >= TABLE_DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    shadow_table[shadow_count] = v;
                    shadow_count++;
                    r.found_position = POS_W'(shadow_count);
                end
            end
            FN_INSERT:
            begin
                if (shadow_count >= TABLE_DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else if (slot == 0 || slot > shadow_count + 1)
                begin
                    r.status = ST_BADPOS;
                end
                else
                begin
                    for (int k = shadow_count; k >= slot; k--)
                    begin
                        shadow_table[k] = shadow_table[k-1];
                    end
                    shadow_table[slot-1] = v;
                    shadow_count++;
                    r.found_position = p;
                end
            end
            FN_DELETE:
            begin
                hit = first_hit(v);
                if (hit == 0)
                begin
                    r.status = ST_NOTFOUND;
                end
                else
                begin
                    for (int k = hit - 1; k + 1 < shadow_count; k++)
                    begin
                        shadow_table[k] = shadow_table[k+1];
                    end
                    shadow_count--;
                    r.found_position = POS_W'(hit);
                end
            end
            default:
            begin
                hit = first_hit(v);
                if (hit == 0)
                begin
                    r.status = ST_NOTFOUND;
                end
                r.found_position = POS_W'(hit);
            end
        endcase
        r.entry_count = POS_W'(shadow_count);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_count = 0;
            awaited_results.delete();
            fail_count      = 0;
            results_checked = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result word with no command outstanding");
                    fail_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    results_checked++;
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        fail_count++;
                    end
                    if (found_position !== want.found_position)
                    begin
                        $error("found_position: expected %0d, actual %0d",
                               want.found_position, found_position);
                        fail_count++;
                    end
                    if (entry_count !== want.entry_count)
                    begin
                        $error("entry_count: expected %0d, actual %0d",
                               want.entry_count, entry_count);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                awaited_results.push_back(apply_command(func, value, position));
            end
        end
        pending    = awaited_results.size();
        table_fill = shadow_count;
    end

endmodule

FILE: tb/sv/tb_array_insert_delete_search_unit.sv
// Testbench top for array_insert_delete_search_unit: clock, reset, command
// stimulus, random stalls and the verdict. Depends on aids_pkg and aids_table_checker.
module tb_array_insert_delete_search_unit;
    import aids_pkg::*;

    localparam int DEPTH        = TABLE_DEPTH_DEF;
    localparam int RANDOM_WORDS = 1300;
    localparam int POOL_SIZE    = 10;
    localparam int CLK_HALF     = 6;
    localparam int LIMIT_CYCLES = 200000;

    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic [FUNC_W-1:0]        func      = FN_APPEND;
    logic signed [WORD_W-1:0] value     = '0;
    logic [POS_W-1:0]         position  = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [STATUS_W-1:0]      status;
    logic [POS_W-1:0]         found_position;
    logic [POS_W-1:0]         entry_count;

    int fail_count;
    int pending;
    int results_checked;
    int table_fill;

    bit                       calm = 1'b0;
    logic signed [WORD_W-1:0] value_pool [POOL_SIZE];
    int                       op_sent [4] = '{0, 0, 0, 0};

    array_insert_delete_search_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .value          (value),
        .position       (position),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .found_position (found_position),
        .entry_count    (entry_count)
    );

    aids_table_checker #(.TABLE_DEPTH(DEPTH)) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .func            (func),
        .value           (value),
        .position        (position),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .found_position  (found_position),
        .entry_count     (entry_count),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .table_fill      (table_fill)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_stall <= !calm && ($urandom_range(0, 99) < 8);
    end

    function automatic bit take_break();
        return !calm && ($urandom_range(0, 99) < 8);
    endfunction

    function automatic logic signed [WORD_W-1:0] pick_value();
        if ($urandom_range(0, 4) == 0)
        begin
            return $urandom;
        end
        return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(
        input logic [FUNC_W-1:0]        f,
        input logic signed [WORD_W-1:0] v,
        input logic [POS_W-1:0]         p
    );
        while (take_break())
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        value    <= v;
        position <= p;
        op_sent[f]++;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    initial
    begin
        logic signed [WORD_W-1:0] last_word;
        logic [FUNC_W-1:0]        f;
        logic [POS_W-1:0]         p;
        int                       roll;
        bit                       grow;

        value_pool[0] = WORD_MIN;
        value_pool[1] = WORD_MAX;
        value_pool[2] = '0;
        value_pool[3] = -32'sd1;
        value_pool[4] = 32'sd1;
        for (int i = 5; i < POOL_SIZE; i++)
        begin
            value_pool[i] = $urandom;
        end

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty table, bad positions, then a small table with duplicates
        send_word(FN_SEARCH, 32'sd5, 5'd0);
        send_word(FN_DELETE, 32'sd5, 5'd31);
        send_word(FN_INSERT, 32'sd7, 5'd0);
        send_word(FN_INSERT, 32'sd7, 5'd2);
        send_word(FN_INSERT, 32'sd7, 5'd1);
        send_word(FN_APPEND, WORD_MIN, 5'd0);
        send_word(FN_APPEND, WORD_MAX, 5'd0);
        send_word(FN_INSERT, '0, 5'd4);
        send_word(FN_INSERT, -32'sd1, 5'd1);
        send_word(FN_INSERT, WORD_MAX, 5'd3);
        send_word(FN_SEARCH, WORD_MAX, 5'd0);
        send_word(FN_DELETE, WORD_MAX, 5'd0);
        send_word(FN_SEARCH, WORD_MAX, 5'd0);
        send_word(FN_INSERT, 32'sd9, 5'd7);

        // fill up, then full-table cases
        last_word = 32'sd1000;
        while (table_fill < DEPTH)
        begin
            last_word = last_word + 32'sd1;
            send_word(FN_APPEND, last_word, 5'd0);
        end
        send_word(FN_APPEND, 32'sd3, 5'd0);
        send_word(FN_INSERT, 32'sd3, 5'd0);
        send_word(FN_INSERT, 32'sd3, 5'd31);
        send_word(FN_SEARCH, last_word, 5'd0);
        send_word(FN_DELETE, -32'sd1, 5'd0);
        send_word(FN_DELETE, last_word, 5'd0);
        send_word(FN_SEARCH, 32'sh5555_5555, 5'd0);
        send_word(FN_SEARCH, 32'shaaaa_aaaa, 5'd0);

        // alternating grow and drain phases, with one stall-free stretch
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            calm = (n >= 600 && n < 850);
            grow = ((n / 90) % 2) == 0;
            roll = $urandom_range(0, 99);
            if (grow)
            begin
                f = roll < 35 ? FN_APPEND : roll < 65 ? FN_INSERT :
                    roll < 80 ? FN_DELETE : FN_SEARCH;
            end
            else
            begin
                f = roll < 10 ? FN_APPEND : roll < 20 ? FN_INSERT :
                    roll < 70 ? FN_DELETE : FN_SEARCH;
            end
            if (f == FN_INSERT && $urandom_range(0, 4) != 0)
            begin
                p = POS_W'($urandom_range(1, table_fill + 1));
            end
            else
            begin
                p = POS_W'($urandom_range(0, 31));
            end
            send_word(f, pick_value(), p);
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);

        $display("Sent %0d append, %0d insert, %0d delete and %0d search words;",
                 op_sent[FN_APPEND], op_sent[FN_INSERT], op_sent[FN_DELETE],
                 op_sent[FN_SEARCH]);
        $display("%0d results checked over fill/drain phases with random stalls.",
                 results_checked);
        if (fail_count == 0)
        begin
            $display("array_insert_delete_search_unit regression: pass");
        end
        else
        begin
            $display("array_insert_delete_search_unit regression: fail");
        end
        $finish;
    end

    initial
    begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("array_insert_delete_search_unit regression: fail");
        $finish;
    end

endmodule
